FILE: hdl/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// Holds field widths, op and register codes, controller states and the
// command and status words between controller and datapath. No dependencies.
package dpb_pkg;

  localparam int NCOEF      = 21;
  localparam int COEF_W     = 32;
  localparam int DEPTH_W    = 32;
  localparam int CIDX_W     = 5;
  localparam int PIX_W      = 12;
  localparam int WORLD_W    = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SIDE_REG_W = 13;
  localparam int CLIP_W     = 12;
  localparam int SIDE_RESET = 4096;

  // coefficient store layout
  localparam int K_BASE = 0;
  localparam int R_BASE = 9;
  localparam int T_BASE = 18;

  typedef enum logic [0:0] {
    OP_COEF  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_REJECT  = 3'd0,
    CFG_HIGH_REJECT = 3'd1,
    CFG_WIDTH       = 3'd2,
    CFG_HEIGHT      = 3'd3,
    CFG_CLIP_LEFT   = 3'd4,
    CFG_CLIP_RIGHT  = 3'd5,
    CFG_CLIP_TOP    = 3'd6,
    CFG_CLIP_BOTTOM = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CAM0, ST_CAM1, ST_CAM2,
    ST_SCL0, ST_SCL1, ST_SCL2, ST_SCL3,
    ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6, ST_W7,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_KCOL, MUL_KROW, MUL_CLO, MUL_CHI, MUL_SLO, MUL_SHI
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_KSUM, ACC_ADD, ACC_LDB, ACC_ADDH
  } acc_op_t;

  typedef enum logic [1:0] {
    WS_HOLD, WS_INIT, WS_ADD
  } ws_op_t;

  typedef struct packed {
    logic       load_pix;
    logic       wr_coef;
    mul_op_t    mul_op;
    logic [1:0] sel;
    acc_op_t    acc_op;
    logic       s_load;
    ws_op_t     ws_op;
    logic       out_load;
  } dpb_cmd_t;

  typedef struct packed {
    logic pass;
  } dpb_status_t;

endpackage

FILE: hdl/dpb_if.sv
// Stream interfaces for the input words and the result words.
// Depends on dpb_pkg for the field widths.
interface dpb_in_if;
  import dpb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [DEPTH_W-1:0]        depth;
  logic [CIDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]  coef_value;

  modport source (output valid, op, depth, coef_index, coef_value, input ready);
  modport sink   (input valid, op, depth, coef_index, coef_value, output ready);
endinterface

interface dpb_out_if;
  import dpb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [PIX_W-1:0]          pixel_column;
  logic [PIX_W-1:0]          pixel_row;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_y;
  logic signed [WORLD_W-1:0] world_z;

  modport source (output valid, pixel_column, pixel_row, world_x, world_y, world_z,
                  input ready);
  modport sink   (input valid, pixel_column, pixel_row, world_x, world_y, world_z,
                  output ready);
endinterface

FILE: hdl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block.
// Depends on dpb_pkg, dpb_if, dpb_ctrl and dpb_datapath.
//
// Takes a raster of depth pixels (op 1) and coefficient words (op 0) on din
// and returns one point per surviving pixel on dout, in input order. A
// coefficient word or a dropped pixel is taken in the idle state, which
// it does not leave. A surviving pixel steps through the camera, scaling,
// rotation and emit states before its point is loaded into the output
// register. There are three lanes, one per world axis, each with a single
// 33x33 multiplier that forms the camera ray, the depth scaling and the
// three rotation terms in 32-bit halves. The next word is accepted once
// that point is loaded, while it still waits on dout. The coefficient store
// has no reset: write all 21 words before the first pixel. Configuration
// registers are to be written only while the block is idle (not enforced by
// the block); a coefficient word with a valid index restarts the raster.
module depth_pixel_backprojection #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
  dpb_in_if.sink                         din,
  dpb_out_if.source                      dout
);
  import dpb_pkg::*;

  dpb_cmd_t    cmd;
  dpb_status_t status;

  dpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_op     (din.op),
    .in_ready  (din.ready),
    .out_ready (dout.ready),
    .out_valid (dout.valid),
    .status    (status),
    .cmd       (cmd)
  );

  dpb_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_depth      (din.depth),
    .in_coef_index (din.coef_index),
    .in_coef_value (din.coef_value),
    .cmd           (cmd),
    .status        (status),
    .pixel_column  (dout.pixel_column),
    .pixel_row     (dout.pixel_row),
    .world_x       (dout.world_x),
    .world_y       (dout.world_y),
    .world_z       (dout.world_z)
  );

endmodule

FILE: hdl/dpb_ctrl.sv
// Sequencer for the back-projection datapath: accepts words, steps the
// multiply schedule and owns the result valid flag. Depends on dpb_pkg.
module dpb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  dpb_pkg::dpb_status_t status,
  output dpb_pkg::dpb_cmd_t    cmd
);
  import dpb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_PIXEL) begin
            cmd.load_pix = 1'b1;
            if (status.pass) state_next = ST_CAM0;
          end else begin
            cmd.wr_coef = 1'b1;
          end
        end
      end
      // camera ray: K row times [col,row,1]
      ST_CAM0: begin
        cmd.mul_op = MUL_KCOL;
        state_next = ST_CAM1;
      end
      ST_CAM1: begin
        cmd.mul_op = MUL_KROW;
        cmd.acc_op = ACC_KSUM;
        state_next = ST_CAM2;
      end
      ST_CAM2: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_SCL0;
      end
      // scale by depth in two halves, then subtract translation
      ST_SCL0: begin
        cmd.mul_op = MUL_CLO;
        state_next = ST_SCL1;
      end
      ST_SCL1: begin
        cmd.mul_op = MUL_CHI;
        cmd.acc_op = ACC_LDB;
        state_next = ST_SCL2;
      end
      ST_SCL2: begin
        cmd.acc_op = ACC_ADDH;
        state_next = ST_SCL3;
      end
      ST_SCL3: begin
        cmd.s_load = 1'b1;
        state_next = ST_W0;
      end
      // rotation: three terms, multiplier overlapped with the accumulate
      ST_W0: begin
        cmd.mul_op = MUL_SLO;
        cmd.sel    = 2'd0;
        state_next = ST_W1;
      end
      ST_W1: begin
        cmd.mul_op = MUL_SHI;
        cmd.sel    = 2'd0;
        cmd.acc_op = ACC_LDB;
        state_next = ST_W2;
      end
      ST_W2: begin
        cmd.mul_op = MUL_SLO;
        cmd.sel    = 2'd1;
        cmd.acc_op = ACC_ADDH;
        state_next = ST_W3;
      end
      ST_W3: begin
        cmd.mul_op = MUL_SHI;
        cmd.sel    = 2'd1;
        cmd.acc_op = ACC_LDB;
        cmd.ws_op  = WS_INIT;
        state_next = ST_W4;
      end
      ST_W4: begin
        cmd.mul_op = MUL_SLO;
        cmd.sel    = 2'd2;
        cmd.acc_op = ACC_ADDH;
        state_next = ST_W5;
      end
      ST_W5: begin
        cmd.mul_op = MUL_SHI;
        cmd.sel    = 2'd2;
        cmd.acc_op = ACC_LDB;
        cmd.ws_op  = WS_ADD;
        state_next = ST_W6;
      end
      ST_W6: begin
        cmd.acc_op = ACC_ADDH;
        state_next = ST_W7;
      end
      ST_W7: begin
        cmd.ws_op  = WS_ADD;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to drain
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_pass_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == OP_PIXEL && status.pass) |=> (state == ST_CAM0))
    else $error("passing pixel did not start the sequence");

  a_drop_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == OP_PIXEL && !status.pass) |=> (state == ST_IDLE))
    else $error("dropped pixel started the sequence");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("result valid raised outside the emit step");

endmodule

FILE: hdl/dpb_datapath.sv
// Datapath: configuration registers, raster counters, reject tests,
// coefficient store and three multiply lanes (one per world axis).
// Depends on dpb_pkg; driven by dpb_ctrl through dpb_cmd_t.
module dpb_datapath #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [dpb_pkg::DEPTH_W-1:0]      in_depth,
  input  logic [dpb_pkg::CIDX_W-1:0]       in_coef_index,
  input  logic signed [dpb_pkg::COEF_W-1:0] in_coef_value,
  input  dpb_pkg::dpb_cmd_t                cmd,
  output dpb_pkg::dpb_status_t             status,
  output logic [dpb_pkg::PIX_W-1:0]        pixel_column,
  output logic [dpb_pkg::PIX_W-1:0]        pixel_row,
  output logic signed [dpb_pkg::WORLD_W-1:0] world_x,
  output logic signed [dpb_pkg::WORLD_W-1:0] world_y,
  output logic signed [dpb_pkg::WORLD_W-1:0] world_z
);
  import dpb_pkg::*;

  localparam int CW     = $clog2(MAX_SIDE);
  localparam int SW     = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = ((SW > CLIP_W) ? SW : CLIP_W) + 1;
  localparam int LO_W   = 32;
  localparam int MOP_W  = 33;
  localparam int PROD_W = 2 * MOP_W;
  localparam int ACC_W  = 92;
  localparam int S_W    = 60;
  localparam int WSUM_W = 63;
  localparam int FRAC   = 24;
  localparam logic signed [ACC_W-1:0]  BIAS    = ACC_W'((1 << FRAC) - 1);
  localparam logic signed [ACC_W-1:0]  CAP_POS = ACC_W'(1) << 60;
  localparam logic signed [ACC_W-1:0]  CAP_NEG = -CAP_POS;
  localparam logic signed [WSUM_W-1:0] W_MAX   = WSUM_W'(64'sd549755813887);
  localparam logic signed [WSUM_W-1:0] W_MIN   = WSUM_W'(-64'sd549755813888);

  function automatic logic [SW-1:0] eff_side(input logic [SIDE_REG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) return SW'(1);
    else if (x > 32'(MAX_SIDE)) return SW'(MAX_SIDE);
    else return SW'(x);
  endfunction

  function automatic logic signed [WORLD_W-1:0] sat_world(input logic signed [WSUM_W-1:0] v);
    if (v > W_MAX) return WORLD_W'(W_MAX);
    else if (v < W_MIN) return WORLD_W'(W_MIN);
    else return WORLD_W'(v);
  endfunction

  // configuration
  logic [DEPTH_W-1:0]    low_reject, high_reject;
  logic [SIDE_REG_W-1:0] image_width, image_height;
  logic [CLIP_W-1:0]     clip_left, clip_right, clip_top, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_reject   <= '0;
      high_reject  <= '1;
      image_width  <= SIDE_REG_W'(SIDE_RESET);
      image_height <= SIDE_REG_W'(SIDE_RESET);
      clip_left    <= '0;
      clip_right   <= '0;
      clip_top     <= '0;
      clip_bottom  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_REJECT:  low_reject   <= cfg_data[DEPTH_W-1:0];
        CFG_HIGH_REJECT: high_reject  <= cfg_data[DEPTH_W-1:0];
        CFG_WIDTH:       image_width  <= cfg_data[SIDE_REG_W-1:0];
        CFG_HEIGHT:      image_height <= cfg_data[SIDE_REG_W-1:0];
        CFG_CLIP_LEFT:   clip_left    <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_RIGHT:  clip_right   <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_TOP:    clip_top     <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_BOTTOM: clip_bottom  <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // raster counters and reject tests
  logic [CW-1:0]    col, row;
  logic [CMP_W-1:0] col_ext, row_ext, w_ext, h_ext;
  logic             col_wrap, row_wrap;

  assign col_ext  = CMP_W'(col);
  assign row_ext  = CMP_W'(row);
  assign w_ext    = CMP_W'(eff_side(image_width));
  assign h_ext    = CMP_W'(eff_side(image_height));
  assign col_wrap = (col_ext + CMP_W'(1)) >= w_ext;
  assign row_wrap = (row_ext + CMP_W'(1)) >= h_ext;

  // row > h - bottom written as row + bottom > h, likewise for columns
  assign status.pass = !(in_depth <= low_reject) && !(in_depth >= high_reject) &&
                       !(row_ext < CMP_W'(clip_top)) &&
                       !((row_ext + CMP_W'(clip_bottom)) > h_ext) &&
                       !(col_ext < CMP_W'(clip_left)) &&
                       !((col_ext + CMP_W'(clip_right)) > w_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.wr_coef && (in_coef_index < CIDX_W'(NCOEF))) begin
      col <= '0;
      row <= '0;
    end else if (cmd.load_pix) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : CW'(row_ext + CMP_W'(1));
      end else begin
        col <= CW'(col_ext + CMP_W'(1));
      end
    end
  end

  logic [CW-1:0]      px_col, px_row;
  logic [DEPTH_W-1:0] px_depth;

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      px_col   <= col;
      px_row   <= row;
      px_depth <= in_depth;
    end
  end

  // coefficient store, lane-sliced so each lane reads only its own row
  logic signed [COEF_W-1:0] kmat [3][3];
  logic signed [COEF_W-1:0] rmat [3][3];
  logic signed [COEF_W-1:0] tvec [3];

  always_ff @(posedge clk) begin
    if (cmd.wr_coef) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (in_coef_index == CIDX_W'(K_BASE + 3 * k + j)) kmat[k][j] <= in_coef_value;
          if (in_coef_index == CIDX_W'(R_BASE + 3 * k + j)) rmat[k][j] <= in_coef_value;
        end
        if (in_coef_index == CIDX_W'(T_BASE + k)) tvec[k] <= in_coef_value;
      end
    end
  end

  // lanes
  logic signed [MOP_W-1:0]  ma [3];
  logic signed [MOP_W-1:0]  mb [3];
  logic signed [PROD_W-1:0] prod [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W-1:0]  prod_ext [3];
  logic signed [ACC_W-1:0]  tq [3];
  logic signed [ACC_W-1:0]  clamped [3];
  logic                     pneg [3];
  logic signed [S_W-1:0]    sreg [3];
  logic signed [WSUM_W-1:0] wsum [3];
  logic signed [S_W-1:0]    s_sel;

  assign s_sel = sreg[cmd.sel];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (cmd.mul_op)
        MUL_KCOL: begin
          ma[k] = MOP_W'(kmat[k][0]);
          mb[k] = MOP_W'(px_col);
        end
        MUL_KROW: begin
          ma[k] = MOP_W'(kmat[k][1]);
          mb[k] = MOP_W'(px_row);
        end
        MUL_CLO: begin
          ma[k] = {1'b0, acc[k][LO_W-1:0]};
          mb[k] = {1'b0, px_depth};
        end
        MUL_CHI: begin
          ma[k] = acc[k][LO_W+MOP_W-1:LO_W];
          mb[k] = {1'b0, px_depth};
        end
        MUL_SLO: begin
          ma[k] = {1'b0, s_sel[LO_W-1:0]};
          mb[k] = MOP_W'(rmat[k][cmd.sel]);
        end
        MUL_SHI: begin
          ma[k] = MOP_W'($signed(s_sel[S_W-1:LO_W]));
          mb[k] = MOP_W'(rmat[k][cmd.sel]);
        end
        default: begin
          ma[k] = '0;
          mb[k] = '0;
        end
      endcase
      prod_ext[k] = ACC_W'(prod[k]);
      // truncation toward zero: the bias was added while accumulating
      tq[k] = acc[k] >>> FRAC;
      if (tq[k] > CAP_POS) clamped[k] = CAP_POS;
      else if (tq[k] < CAP_NEG) clamped[k] = CAP_NEG;
      else clamped[k] = tq[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod[k] <= ma[k] * mb[k];
      if (cmd.mul_op == MUL_CLO) pneg[k] <= acc[k][ACC_W-1];
      else if (cmd.mul_op == MUL_SLO) pneg[k] <= s_sel[S_W-1] ^ rmat[k][cmd.sel][COEF_W-1];

      unique case (cmd.acc_op)
        ACC_KSUM: acc[k] <= ACC_W'(kmat[k][2]) + prod_ext[k];
        ACC_ADD:  acc[k] <= acc[k] + prod_ext[k];
        ACC_LDB:  acc[k] <= prod_ext[k] + (pneg[k] ? BIAS : '0);
        ACC_ADDH: acc[k] <= acc[k] + (prod_ext[k] <<< LO_W);
        default: ;
      endcase

      if (cmd.s_load) sreg[k] <= S_W'(tq[k] - ACC_W'(tvec[k]));

      unique case (cmd.ws_op)
        WS_INIT: wsum[k] <= WSUM_W'(clamped[k]);
        WS_ADD:  wsum[k] <= wsum[k] + WSUM_W'(clamped[k]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_column <= PIX_W'(px_col);
      pixel_row    <= PIX_W'(px_row);
      world_x      <= sat_world(wsum[0]);
      world_y      <= sat_world(wsum[1]);
      world_z      <= sat_world(wsum[2]);
    end
  end

endmodule
